// File: hdl/eos_pkg.sv
// shared types, constants and sine coefficients for the encoder odometry block
// no dependencies
`default_nettype none

package eos_pkg;

   localparam int TRIG_BITS = 16;
   localparam int TRIG_W    = TRIG_BITS + 1;
   localparam int TRIG_CW   = $clog2(TRIG_W);

   localparam int DIV_BITS  = 24;
   localparam int DIV_CW    = $clog2(DIV_BITS);

   localparam logic [63:0] SIN_A30 = 64'd1686629713;
   localparam logic [63:0] SIN_B30 = 64'd688904866;
   localparam logic [63:0] SIN_C30 = 64'd76016977;

   localparam logic [63:0] SIN_A_FULL = (SIN_A30 + (64'd1 << (29 - TRIG_BITS))) >> (30 - TRIG_BITS);
   localparam logic [63:0] SIN_B_FULL = (SIN_B30 + (64'd1 << (29 - TRIG_BITS))) >> (30 - TRIG_BITS);
   localparam logic [63:0] SIN_C_FULL = (SIN_C30 + (64'd1 << (29 - TRIG_BITS))) >> (30 - TRIG_BITS);

   localparam logic [TRIG_W-1:0] SIN_A = SIN_A_FULL[TRIG_W-1:0];
   localparam logic [TRIG_W-1:0] SIN_B = SIN_B_FULL[TRIG_W-1:0];
   localparam logic [TRIG_W-1:0] SIN_C = SIN_C_FULL[TRIG_W-1:0];

   localparam logic [14:0] SIN_MAX = 15'd32767;

   localparam logic CSR_MM_PER_COUNT = 1'b0;
   localparam logic CSR_FILTER_KEEP  = 1'b1;

   typedef struct packed {
      logic [15:0] raw_count;
      logic [15:0] elapsed_us;
      logic [15:0] heading;
   } req_type;

   typedef struct packed {
      logic signed [47:0] position_count;
      logic signed [39:0] distance_mm;
      logic signed [23:0] speed_value;
      logic signed [39:0] pos_x_mm;
      logic signed [39:0] pos_y_mm;
      logic               time_error;
   } rsp_type;

   typedef struct packed {
      logic        busy;
      logic        neg;
      logic [14:0] mag;
   } trig_stat_type;

   typedef struct packed {
      logic                busy;
      logic [DIV_BITS-1:0] quo;
   } div_stat_type;

endpackage

`default_nettype wire

// File: hdl/encoder_odometry_speed.sv
// encoder odometry top level: count extension, speed filter, x/y integration
// depends on eos_pkg, eos_trig, eos_div
// one request at a time: the block takes no new request while one is in
// flight. the path is set by the two bit-serial sine units followed by the
// serial step product. reset is synchronous: config returns to its
// defaults and all odometry state clears
`default_nettype none

module encoder_odometry_speed (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output wire logic             req_ready,
   input  wire eos_pkg::req_type req_payload,
   output wire logic             rsp_valid,
   input  wire logic             rsp_ready,
   output eos_pkg::rsp_type      rsp_payload,
   input  wire logic             csr_wr_en,
   input  wire logic             csr_index,
   input  wire logic [23:0]      csr_wdata
);

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_PREP = 5'd1;
   localparam logic [4:0] ST_ABS  = 5'd2;
   localparam logic [4:0] ST_MUL1 = 5'd3;
   localparam logic [4:0] ST_DIST = 5'd4;
   localparam logic [4:0] ST_SPD  = 5'd5;
   localparam logic [4:0] ST_N1   = 5'd6;
   localparam logic [4:0] ST_N2   = 5'd7;
   localparam logic [4:0] ST_DIVS = 5'd8;
   localparam logic [4:0] ST_DIVW = 5'd9;
   localparam logic [4:0] ST_F1   = 5'd10;
   localparam logic [4:0] ST_F2   = 5'd11;
   localparam logic [4:0] ST_XYW  = 5'd12;
   localparam logic [4:0] ST_MUL2 = 5'd13;
   localparam logic [4:0] ST_XYS  = 5'd14;
   localparam logic [4:0] ST_XYA  = 5'd15;
   localparam logic [4:0] ST_OUT  = 5'd16;

   localparam logic signed [39:0] MAX40  = 40'sh7F_FFFF_FFFF;
   localparam logic signed [39:0] MIN40  = 40'sh80_0000_0000;
   localparam logic signed [23:0] SPD_HI = 24'sh7F_FFFF;
   localparam logic signed [23:0] SPD_LO = 24'sh80_0000;

   function automatic logic signed [39:0] sat40(input logic [55:0] mag, input logic neg);
      logic [55:0] lim_neg;
      lim_neg = 56'd1 << 39;
      if (neg) begin
         sat40 = (mag > lim_neg) ? MIN40 : -$signed(mag[39:0]);
      end else begin
         sat40 = (mag > {16'd0, MAX40}) ? MAX40 : $signed(mag[39:0]);
      end
   endfunction

   function automatic logic signed [39:0] sat_add40(input logic signed [39:0] a,
                                                    input logic signed [39:0] b);
      logic [40:0] s;
      s = {a[39], a} + {b[39], b};
      if (s[40] != s[39]) begin
         sat_add40 = s[40] ? MIN40 : MAX40;
      end else begin
         sat_add40 = $signed(s[39:0]);
      end
   endfunction

   logic [4:0]  state_ff;
   logic [23:0] mpc_ff;
   logic [8:0]  keep_ff;

   logic [15:0]        last_raw_ff;
   logic [31:0]        wrap_ff;
   logic [47:0]        prev_ff;
   logic signed [23:0] speed_ff;
   logic signed [39:0] x_ff;
   logic signed [39:0] y_ff;

   logic [47:0]        pos_ff;
   logic [15:0]        elapsed_ff;
   logic [47:0]        delta_ff;
   logic [47:0]        pmag_ff;
   logic               pneg_ff;
   logic [47:0]        dmag_ff;
   logic               dneg_ff;
   logic [23:0]        mb_ff;
   logic [4:0]         cnt_ff;
   logic [71:0]        accp_ff;
   logic [71:0]        accq_ff;
   logic signed [39:0] dist_ff;
   logic               terr_ff;
   logic [64:0]        n_ff;
   logic signed [23:0] inst_ff;
   logic signed [33:0] prod_ff;
   logic [14:0]        cmb_ff;
   logic [14:0]        smb_ff;
   logic [86:0]        accx_ff;
   logic [86:0]        accy_ff;
   logic signed [39:0] stepx_ff;
   logic signed [39:0] stepy_ff;
   eos_pkg::rsp_type   rsp_ff;
   logic               rsp_valid_ff;

   logic [31:0]            wrap_in;
   logic                   accept;
   logic                   trig_start;
   logic                   div_start;
   eos_pkg::trig_stat_type cos_stat;
   eos_pkg::trig_stat_type sin_stat;
   eos_pkg::div_stat_type  div_stat;
   logic [15:0]            cos_angle;
   logic [54:0]            p55;
   logic [55:0]            dist_mag;
   logic [55:0]            x_mag;
   logic [55:0]            y_mag;
   logic [8:0]             k_eff;
   logic [8:0]             k_new;
   logic signed [34:0]     fsum;
   logic signed [34:0]     fsum_rnd;
   logic signed [24:0]     quo_neg;
   logic signed [23:0]     inst_sat;

   always_comb begin
      wrap_in = wrap_ff;
      if (req_payload.raw_count[15:14] == 2'b00 && last_raw_ff[15:14] == 2'b11) begin
         wrap_in = wrap_ff + 32'd1;
      end else if (req_payload.raw_count[15:14] == 2'b11 && last_raw_ff[15:14] == 2'b00) begin
         wrap_in = wrap_ff - 32'd1;
      end
      accept     = req_valid && (state_ff == ST_IDLE);
      trig_start = accept;
      div_start  = (state_ff == ST_DIVS) && (n_ff[64:32] < {17'd0, elapsed_ff});
      cos_angle  = req_payload.heading + 16'd16384;
      p55        = accp_ff[54:0];
      dist_mag   = accq_ff[71:16] + {55'd0, accq_ff[15]};
      x_mag      = accx_ff[86:31] + {55'd0, accx_ff[30]};
      y_mag      = accy_ff[86:31] + {55'd0, accy_ff[30]};
      k_eff      = (keep_ff > 9'd256) ? 9'd256 : keep_ff;
      k_new      = 9'd256 - k_eff;
      fsum       = 35'(prod_ff) +
                   ($signed({26'd0, k_new}) * $signed({{11{inst_ff[23]}}, inst_ff}));
      fsum_rnd   = fsum + 35'sd128;
      quo_neg    = -$signed({1'b0, div_stat.quo});
      inst_sat   = dneg_ff ? SPD_LO : SPD_HI;
   end

   eos_trig u_cos (
      .clock (clock),
      .reset (reset),
      .start (trig_start),
      .angle (cos_angle),
      .stat  (cos_stat)
   );

   eos_trig u_sin (
      .clock (clock),
      .reset (reset),
      .start (trig_start),
      .angle (req_payload.heading),
      .stat  (sin_stat)
   );

   eos_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num_hi (n_ff[47:32]),
      .num_lo (n_ff[31:8]),
      .den    (elapsed_ff),
      .stat   (div_stat)
   );

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mpc_ff  <= 24'd240973;
         keep_ff <= 9'd205;
      end else if (csr_wr_en) begin
         case (csr_index)
            eos_pkg::CSR_MM_PER_COUNT: mpc_ff  <= csr_wdata;
            eos_pkg::CSR_FILTER_KEEP:  keep_ff <= csr_wdata[8:0];
            default: begin
            end
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_ff.position_count <= $signed(pos_ff);
         rsp_ff.distance_mm    <= dist_ff;
         rsp_ff.speed_value    <= speed_ff;
         rsp_ff.pos_x_mm       <= x_ff;
         rsp_ff.pos_y_mm       <= y_ff;
         rsp_ff.time_error     <= terr_ff;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         last_raw_ff <= '0;
         wrap_ff     <= '0;
         prev_ff     <= '0;
         speed_ff    <= '0;
         x_ff        <= '0;
         y_ff        <= '0;
         cnt_ff      <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  wrap_ff     <= wrap_in;
                  last_raw_ff <= req_payload.raw_count;
                  pos_ff      <= {wrap_in, req_payload.raw_count};
                  elapsed_ff  <= req_payload.elapsed_us;
                  state_ff    <= ST_PREP;
               end
            end
            ST_PREP: begin
               delta_ff <= pos_ff - prev_ff;
               pmag_ff  <= pos_ff[47] ? (48'd0 - pos_ff) : pos_ff;
               pneg_ff  <= pos_ff[47];
               prev_ff  <= pos_ff;
               state_ff <= ST_ABS;
            end
            ST_ABS: begin
               dmag_ff  <= delta_ff[47] ? (48'd0 - delta_ff) : delta_ff;
               dneg_ff  <= delta_ff[47];
               mb_ff    <= mpc_ff;
               accp_ff  <= '0;
               accq_ff  <= '0;
               cnt_ff   <= '0;
               state_ff <= ST_MUL1;
            end
            ST_MUL1: begin
               accp_ff <= {accp_ff[70:0], 1'b0} + (mb_ff[23] ? {24'd0, dmag_ff} : 72'd0);
               accq_ff <= {accq_ff[70:0], 1'b0} + (mb_ff[23] ? {24'd0, pmag_ff} : 72'd0);
               mb_ff   <= {mb_ff[22:0], 1'b0};
               cnt_ff  <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd23) begin
                  state_ff <= ST_DIST;
               end
            end
            ST_DIST: begin
               dist_ff  <= sat40(dist_mag, pneg_ff);
               state_ff <= ST_SPD;
            end
            ST_SPD: begin
               terr_ff <= (elapsed_ff == 16'd0);
               if (elapsed_ff == 16'd0) begin
                  state_ff <= ST_XYW;
               end else if (dmag_ff == 48'd0) begin
                  speed_ff <= '0;
                  state_ff <= ST_XYW;
               end else if (mpc_ff == 24'd0) begin
                  inst_ff  <= '0;
                  state_ff <= ST_F1;
               end else if (dmag_ff[47:40] != 8'd0 || accp_ff > (72'd1 << 54)) begin
                  inst_ff  <= inst_sat;
                  state_ff <= ST_F1;
               end else begin
                  state_ff <= ST_N1;
               end
            end
            ST_N1: begin
               // times 1024 minus times 16, the rest of times 1000 follows
               n_ff     <= {p55, 10'd0} - {6'd0, p55, 4'd0};
               state_ff <= ST_N2;
            end
            ST_N2: begin
               n_ff     <= n_ff - {7'd0, p55, 3'd0} + {42'd0, elapsed_ff, 7'd0};
               state_ff <= ST_DIVS;
            end
            ST_DIVS: begin
               if (div_start) begin
                  state_ff <= ST_DIVW;
               end else begin
                  inst_ff  <= inst_sat;
                  state_ff <= ST_F1;
               end
            end
            ST_DIVW: begin
               if (!div_stat.busy) begin
                  if (dneg_ff) begin
                     inst_ff <= (div_stat.quo > 24'h80_0000) ? SPD_LO : quo_neg[23:0];
                  end else begin
                     inst_ff <= (div_stat.quo > 24'h7F_FFFF) ? SPD_HI : $signed(div_stat.quo);
                  end
                  state_ff <= ST_F1;
               end
            end
            ST_F1: begin
               prod_ff  <= $signed({1'b0, k_eff}) * speed_ff;
               state_ff <= ST_F2;
            end
            ST_F2: begin
               speed_ff <= fsum_rnd[31:8];
               state_ff <= ST_XYW;
            end
            ST_XYW: begin
               if (!cos_stat.busy && !sin_stat.busy) begin
                  cmb_ff   <= cos_stat.mag;
                  smb_ff   <= sin_stat.mag;
                  accx_ff  <= '0;
                  accy_ff  <= '0;
                  cnt_ff   <= '0;
                  state_ff <= ST_MUL2;
               end
            end
            ST_MUL2: begin
               accx_ff <= {accx_ff[85:0], 1'b0} + (cmb_ff[14] ? {15'd0, accp_ff} : 87'd0);
               accy_ff <= {accy_ff[85:0], 1'b0} + (smb_ff[14] ? {15'd0, accp_ff} : 87'd0);
               cmb_ff  <= {cmb_ff[13:0], 1'b0};
               smb_ff  <= {smb_ff[13:0], 1'b0};
               cnt_ff  <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd14) begin
                  state_ff <= ST_XYS;
               end
            end
            ST_XYS: begin
               stepx_ff <= sat40(x_mag, dneg_ff ^ cos_stat.neg);
               stepy_ff <= sat40(y_mag, dneg_ff ^ sin_stat.neg);
               state_ff <= ST_XYA;
            end
            ST_XYA: begin
               x_ff     <= sat_add40(x_ff, stepx_ff);
               y_ff     <= sat_add40(y_ff, stepy_ff);
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// File: hdl/eos_trig.sv
// bit-serial sine unit: quarter-wave polynomial, one multiplier bit per cycle
// depends on eos_pkg
`default_nettype none

module eos_trig (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [15:0]            angle,
   output eos_pkg::trig_stat_type      stat
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   localparam int W = eos_pkg::TRIG_W;

   logic [1:0]                  state_ff;
   logic [1:0]                  step_ff;
   logic [eos_pkg::TRIG_CW-1:0] cnt_ff;
   logic [W-1:0]                a_ff;
   logic [W-1:0]                b_ff;
   logic [2*W-1:0]              acc_ff;
   logic [W-1:0]                z_ff;
   logic [W-1:0]                z2_ff;
   logic                        neg_ff;
   logic [14:0]                 mag_ff;

   logic [14:0]                      rr;
   logic [15+eos_pkg::TRIG_BITS-1:0] zwide;
   logic [W-1:0]                     z_in;
   logic [2*W-1:0]                   rnd;
   logic [W-1:0]                     res;
   logic [W+14:0]                    o_sum;
   logic [15:0]                      o_val;

   always_comb begin
      rr    = angle[14] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
      zwide = {rr, {eos_pkg::TRIG_BITS{1'b0}}};
      z_in  = zwide[eos_pkg::TRIG_BITS+14:14];
      rnd   = acc_ff + ({{(2*W-1){1'b0}}, 1'b1} << (eos_pkg::TRIG_BITS - 1));
      res   = rnd[eos_pkg::TRIG_BITS+W-1:eos_pkg::TRIG_BITS];
      o_sum = {res, 15'd0} + ({{(W+14){1'b0}}, 1'b1} << (eos_pkg::TRIG_BITS - 1));
      o_val = o_sum[eos_pkg::TRIG_BITS+15:eos_pkg::TRIG_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= 2'd0;
         cnt_ff   <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  a_ff     <= z_in;
                  b_ff     <= z_in;
                  z_ff     <= z_in;
                  neg_ff   <= angle[15];
                  acc_ff   <= '0;
                  cnt_ff   <= '0;
                  step_ff  <= 2'd0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               acc_ff <= {acc_ff[2*W-2:0], 1'b0} +
                         (b_ff[W-1] ? {{W{1'b0}}, a_ff} : {(2*W){1'b0}});
               b_ff   <= {b_ff[W-2:0], 1'b0};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == eos_pkg::TRIG_CW'(W - 1)) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               acc_ff   <= '0;
               cnt_ff   <= '0;
               step_ff  <= step_ff + 2'd1;
               state_ff <= ST_MUL;
               case (step_ff)
                  2'd0: begin
                     z2_ff <= res;
                     a_ff  <= eos_pkg::SIN_C;
                     b_ff  <= res;
                  end
                  2'd1: begin
                     a_ff <= eos_pkg::SIN_B - res;
                     b_ff <= z2_ff;
                  end
                  2'd2: begin
                     a_ff <= eos_pkg::SIN_A - res;
                     b_ff <= z_ff;
                  end
                  default: begin
                     mag_ff   <= (o_val > {1'b0, eos_pkg::SIN_MAX}) ? eos_pkg::SIN_MAX
                                                                   : o_val[14:0];
                     state_ff <= ST_IDLE;
                  end
               endcase
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign stat.busy = (state_ff != ST_IDLE);
   assign stat.neg  = neg_ff;
   assign stat.mag  = mag_ff;

endmodule

`default_nettype wire

// File: hdl/eos_div.sv
// restoring divider, one quotient bit per cycle, remainder as wide as the divisor
// depends on eos_pkg
`default_nettype none

module eos_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [15:0]                  num_hi,
   input  wire logic [eos_pkg::DIV_BITS-1:0] num_lo,
   input  wire logic [15:0]                  den,
   output eos_pkg::div_stat_type             stat
);

   logic                         busy_ff;
   logic [eos_pkg::DIV_CW-1:0]   cnt_ff;
   logic [15:0]                  rem_ff;
   logic [eos_pkg::DIV_BITS-1:0] lo_ff;
   logic [eos_pkg::DIV_BITS-1:0] quo_ff;
   logic [15:0]                  den_ff;

   logic [16:0] trial;
   logic [16:0] diff;
   logic        fits;

   always_comb begin
      trial = {rem_ff, lo_ff[eos_pkg::DIV_BITS-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = (trial >= {1'b0, den_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         rem_ff  <= num_hi;
         lo_ff   <= num_lo;
         den_ff  <= den;
         quo_ff  <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[15:0] : trial[15:0];
         quo_ff <= {quo_ff[eos_pkg::DIV_BITS-2:0], fits};
         lo_ff  <= {lo_ff[eos_pkg::DIV_BITS-2:0], 1'b0};
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == eos_pkg::DIV_CW'(eos_pkg::DIV_BITS - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.quo  = quo_ff;

endmodule

`default_nettype wire
